// ===== rtl/core/icas_pkg.sv =====
// Shared types, codes and step helpers for the init command ack sequencer.
package icas_pkg;

  // Request kinds carried on the input tuser.
  typedef enum logic [1:0] {
    REQ_BEGIN  = 2'd0,
    REQ_ACK    = 2'd1,
    REQ_EXPIRE = 2'd2,
    REQ_QUERY  = 2'd3
  } req_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_INVALID      = 3'd1,
    ST_STALE        = 3'd2,
    ST_DUPLICATE    = 3'd3,
    ST_OUT_OF_ORDER = 3'd4,
    ST_TIMEOUT      = 3'd5,
    ST_COMPLETE     = 3'd6
  } status_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LTR_ENABLE       = 2'd0;
  localparam logic [1:0] CFG_LAR_ENABLE       = 2'd1;
  localparam logic [1:0] CFG_LTR_GEN2_CAPABLE = 2'd2;

  // Steps that may be skipped, and the terminal step value.
  localparam logic [3:0] STEP_LATENCY = 4'd3;
  localparam logic [3:0] STEP_COUNTRY = 4'd6;
  localparam logic [3:0] STEP_DONE    = 4'd9;

  // Session state. The profile bits are reduced at begin to the two step enables.
  typedef struct packed {
    logic [31:0] session_tag;
    logic [63:0] deadline_us;
    logic [3:0]  step_index;
    logic        active_flag;
    logic        terminal_flag;
    logic        latency_on;
    logic        country_on;
  } state_t;

  // Next enabled step after s. Skippable steps are never adjacent, so one skip suffices.
  function automatic logic [3:0] next_step(input logic [3:0] s, input logic latency_on,
                                           input logic country_on);
    logic [3:0] n;
    n = s + 4'd1;
    if ((n == STEP_LATENCY && !latency_on) || (n == STEP_COUNTRY && !country_on)) begin
      n = n + 4'd1;
    end
    return n;
  endfunction

endpackage

// ===== rtl/core/icas_eval.sv =====
// Request evaluation: next session state and result status for one request.
module icas_eval #(
  parameter int unsigned TIMEOUT_US = 500000
) (
  input  icas_pkg::req_t    req_type,
  input  logic [31:0]       generation,
  input  logic [3:0]        ack_step,
  input  logic [63:0]       now_us,
  input  logic              ltr_enable,
  input  logic              lar_enable,
  input  logic              ltr_gen2_capable,
  input  icas_pkg::state_t  state,
  output icas_pkg::state_t  state_next,
  output icas_pkg::status_t status
);
  import icas_pkg::*;

  logic [64:0] deadline_sum;
  logic        deadline_ovf;
  logic        late;
  logic        running;
  logic [3:0]  step_after;

  // A carry out of the add means the new deadline does not fit in 64 bits.
  assign deadline_sum = {1'b0, now_us} + 65'(TIMEOUT_US);
  assign deadline_ovf = deadline_sum[64];
  assign late         = (now_us >= state.deadline_us);
  assign running      = state.active_flag && !state.terminal_flag;
  assign step_after   = next_step(state.step_index, state.latency_on, state.country_on);

  always_comb begin
    state_next = state;
    status     = ST_OK;
    unique case (req_type)
      REQ_BEGIN: begin
        if (generation == 32'd0 || deadline_ovf) begin
          status = ST_INVALID;
        end else begin
          state_next.session_tag   = generation;
          state_next.deadline_us   = deadline_sum[63:0];
          state_next.step_index    = 4'd0;
          state_next.active_flag   = 1'b1;
          state_next.terminal_flag = 1'b0;
          state_next.latency_on    = ltr_enable && !ltr_gen2_capable;
          state_next.country_on    = lar_enable;
        end
      end
      REQ_ACK: begin
        if (generation == 32'd0 || ack_step >= STEP_DONE) begin
          status = ST_INVALID;
        end else if (generation != state.session_tag) begin
          status = ST_STALE;
        end else if (!running) begin
          status = ST_DUPLICATE;
        end else if (late) begin
          state_next.active_flag   = 1'b0;
          state_next.terminal_flag = 1'b1;
          status                   = ST_TIMEOUT;
        end else if (ack_step != state.step_index) begin
          status = (ack_step < state.step_index) ? ST_DUPLICATE : ST_OUT_OF_ORDER;
        end else begin
          state_next.step_index = step_after;
          if (step_after == STEP_DONE) begin
            state_next.active_flag   = 1'b0;
            state_next.terminal_flag = 1'b1;
            status                   = ST_COMPLETE;
          end else if (deadline_ovf) begin
            state_next.active_flag   = 1'b0;
            state_next.terminal_flag = 1'b1;
            status                   = ST_TIMEOUT;
          end else begin
            state_next.deadline_us = deadline_sum[63:0];
          end
        end
      end
      REQ_EXPIRE: begin
        if (state.session_tag == 32'd0) begin
          status = ST_INVALID;
        end else if (!running) begin
          status = ST_DUPLICATE;
        end else if (!late) begin
          status = ST_OK;
        end else begin
          state_next.active_flag   = 1'b0;
          state_next.terminal_flag = 1'b1;
          status                   = ST_TIMEOUT;
        end
      end
      REQ_QUERY: begin
        if (!running || state.session_tag == 32'd0) begin
          status = ST_INVALID;
        end else if (late) begin
          status = ST_TIMEOUT;
        end else begin
          status = ST_OK;
        end
      end
      default: begin
        status = ST_INVALID;
      end
    endcase
  end

endmodule

// ===== rtl/core/init_command_ack_sequencer.sv =====
// Top level of the init command ack sequencer: stream ports, registers and checks.
// Path: an accepted request is held in the input register and moves into the result
// register when that register is free or being drained.
// Throughput: one request per cycle while the result side drains; the session state
// update is a single 64-bit add and compare between the input and result registers.
// Reset (rst, synchronous, active high) clears the session, the profile registers
// and both valid flags; no clearing pass is needed.
module init_command_ack_sequencer #(
  parameter int unsigned TIMEOUT_US = 500000
) (
  input  logic         clk,
  input  logic         rst,
  // Configuration write port.
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic         cfg_data,
  // Request stream.
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,  // generation[31:0], ack_step[35:32], now_us[99:36], zero pad
  input  logic [1:0]   s_tuser,  // req_type[1:0]
  // Result stream.
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [7:0]   m_tdata   // status[2:0], current_step[6:3], running[7]
);
  import icas_pkg::*;

  // Profile registers, sampled into the session at each begin request.
  logic ltr_enable;
  logic lar_enable;
  logic ltr_gen2_capable;

  // Input register.
  logic        in_valid;
  req_t        in_req;
  logic [31:0] in_generation;
  logic [3:0]  in_ack_step;
  logic [63:0] in_now_us;

  // Session state.
  state_t  state;
  state_t  state_next;
  status_t status_next;

  // Result register.
  logic       out_valid;
  status_t    out_status;
  logic [3:0] out_step;
  logic       out_running;

  logic advance;

  // The held request moves on whenever the result register is free or being drained.
  // The input side stalls only when both registers hold items and the result waits.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      ltr_enable       <= 1'b0;
      lar_enable       <= 1'b0;
      ltr_gen2_capable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LTR_ENABLE:       ltr_enable       <= cfg_data;
        CFG_LAR_ENABLE:       lar_enable       <= cfg_data;
        CFG_LTR_GEN2_CAPABLE: ltr_gen2_capable <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_req        <= req_t'(s_tuser);
      in_generation <= s_tdata[31:0];
      in_ack_step   <= s_tdata[35:32];
      in_now_us     <= s_tdata[99:36];
    end
  end

  icas_eval #(
    .TIMEOUT_US(TIMEOUT_US)
  ) u_eval (
    .req_type        (in_req),
    .generation      (in_generation),
    .ack_step        (in_ack_step),
    .now_us          (in_now_us),
    .ltr_enable      (ltr_enable),
    .lar_enable      (lar_enable),
    .ltr_gen2_capable(ltr_gen2_capable),
    .state           (state),
    .state_next      (state_next),
    .status          (status_next)
  );

  // The session state is updated as the request leaves the input register, so the
  // very next request already sees it.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status  <= status_next;
      out_step    <= state_next.step_index;
      out_running <= state_next.active_flag && !state_next.terminal_flag;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_running, out_step, out_status};

  // A session is never both active and terminal.
  assert property (@(posedge clk) disable iff (rst)
    !(state.active_flag && state.terminal_flag))
    else $error("session both active and terminal");

  // The step index never passes the done marker.
  assert property (@(posedge clk) disable iff (rst)
    state.step_index <= STEP_DONE)
    else $error("step index beyond done");

  // An active session always carries a nonzero generation tag.
  assert property (@(posedge clk) disable iff (rst)
    state.active_flag |-> (state.session_tag != 32'd0))
    else $error("active session with zero tag");

  // A completed sequence reports the done step and is no longer running.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == ST_COMPLETE) |-> (out_step == STEP_DONE && !out_running))
    else $error("complete result with wrong step or running");

endmodule
